// ===== hdl/tnis_pkg.sv =====
// ---------------------------------------------------------------------------
// tnis_pkg
// Shared widths and types for the top-N index selector.
// ---------------------------------------------------------------------------
`default_nettype none

package tnis_pkg;

    localparam int VALUE_W = 48;  // element magnitude
    localparam int KEEP_W  = 7;   // keep count register
    localparam int RANK_W  = 7;   // stored rank per element
    localparam int INDEX_W = 6;   // emitted index

    // One result word on the output channel
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               is_final;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/top_n_index_selector_core.sv =====
// ---------------------------------------------------------------------------
// top_n_index_selector_core
// Loads a list of 48-bit values and emits the indices of the top-ranked ones.
// ---------------------------------------------------------------------------
// Each accepted word stores one element (up to MAX_ITEMS per list). Storing
// element number p walks the p stored entries through the value and rank
// memories, one entry per cycle over their single read port. After the word
// is accepted the block stays busy for the walk, the registered read of the
// last entry, and the write of the new entry. The first element of a list has
// nothing to walk and needs only the write. Ranks are kept current as
// elements arrive: rank = number of larger elements + number of equal
// elements with a lower index. A word with s_is_last set closes the list;
// the block then scans the rank memory, reading and then testing each loaded
// element in turn, and emits, in ascending index order, every index whose
// rank is below the effective keep count, with m_is_final on the last one.
// A kept index waits while m_ready holds the output register. Effective
// keep count: cfg keep_count if nonzero, else half the loaded count (at least
// one); clipped to the loaded count. Words beyond capacity are dropped, but
// their last flag still closes the list. The memories need no clearing: only
// entries written in the current list are read. s_ready is high only between
// words; a finished result may sit in the output register while the next
// word is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module top_n_index_selector_core #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [tnis_pkg::KEEP_W-1:0]  cfg_wr_data,
    // input words
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tnis_pkg::VALUE_W-1:0] s_value,
    input  wire logic                         s_is_last,
    // result words
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tnis_pkg::INDEX_W-1:0]      m_index,
    output logic                              m_is_final
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int VW    = tnis_pkg::VALUE_W;
    localparam int RW    = tnis_pkg::RANK_W;
    localparam int KW    = tnis_pkg::KEEP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT_CHK
    } state_t;

    // control / payload registers
    state_t           state_reg,      state_next;
    logic [CNT_W-1:0] cnt_reg,        cnt_next;
    logic [VW-1:0]    val_reg,        val_next;
    logic             last_reg,       last_next;
    logic [CNT_W-1:0] rd_idx_reg,     rd_idx_next;
    logic             proc_valid_reg, proc_valid_next;
    logic [AW-1:0]    proc_idx_reg,   proc_idx_next;
    logic [RW-1:0]    rank_acc_reg,   rank_acc_next;
    logic [KW-1:0]    k_reg,          k_next;
    logic [CNT_W-1:0] emit_idx_reg,   emit_idx_next;
    logic [KW-1:0]    emit_num_reg,   emit_num_next;
    logic [KW-1:0]    keep_cfg_reg;

    // memory ports
    logic          val_we, val_re;
    logic [AW-1:0] val_waddr, val_raddr;
    logic [VW-1:0] val_rdata;
    logic          rank_we, rank_re;
    logic [AW-1:0] rank_waddr, rank_raddr;
    logic [RW-1:0] rank_wdata, rank_rdata;

    // output stage
    logic                out_load, out_can_load;
    tnis_pkg::out_word_t out_word;

    // effective keep count
    logic [CNT_W-1:0] k_cnt;
    logic [KW-1:0]    k_cnt_ext, k_half, k_auto, k_pick, k_eff;

    logic rd_issue, walk_ge, walk_done, kept, emit_end;

    tnis_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_reg),
        .rd_en   (val_re),
        .rd_addr (val_raddr),
        .rd_data (val_rdata)
    );

    tnis_ram #(.WIDTH(RW), .DEPTH(MAX_ITEMS)) u_rank_ram (
        .aclk    (aclk),
        .wr_en   (rank_we),
        .wr_addr (rank_waddr),
        .wr_data (rank_wdata),
        .rd_en   (rank_re),
        .rd_addr (rank_raddr),
        .rd_data (rank_rdata)
    );

    tnis_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (out_load),
        .load_word  (out_word),
        .can_load   (out_can_load),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_index    (m_index),
        .m_is_final (m_is_final)
    );

    assign s_ready = (state_reg == ST_IDLE);

    // Walk: issue reads 0..cnt-1; in the next cycle compare and update rank.
    assign rd_issue  = (state_reg == ST_WALK) && (rd_idx_reg < cnt_reg);
    assign walk_ge   = (val_rdata >= val_reg);
    assign walk_done = (state_reg == ST_WALK) && !rd_issue && !proc_valid_reg;

    // Keep count uses the count after this word's store (if any).
    assign k_cnt     = walk_done ? (cnt_reg + CNT_W'(1)) : cnt_reg;
    assign k_cnt_ext = KW'(k_cnt);
    assign k_half    = k_cnt_ext >> 1;
    assign k_auto    = (k_half == '0) ? KW'(1) : k_half;
    assign k_pick    = (keep_cfg_reg != '0) ? keep_cfg_reg : k_auto;
    assign k_eff     = (k_pick > k_cnt_ext) ? k_cnt_ext : k_pick;

    // Emission scan
    assign kept     = (rank_rdata < k_reg);
    assign emit_end = ((emit_idx_reg + CNT_W'(1)) == cnt_reg);

    always_comb begin
        val_re     = rd_issue;
        val_raddr  = rd_idx_reg[AW-1:0];
        val_we     = walk_done;
        val_waddr  = cnt_reg[AW-1:0];

        rank_re    = rd_issue || (state_reg == ST_EMIT_RD);
        rank_raddr = (state_reg == ST_WALK) ? rd_idx_reg[AW-1:0] : emit_idx_reg[AW-1:0];
        rank_we    = 1'b0;
        rank_waddr = proc_idx_reg;
        rank_wdata = rank_rdata + RW'(1);
        if (walk_done) begin
            rank_we    = 1'b1;
            rank_waddr = cnt_reg[AW-1:0];
            rank_wdata = rank_acc_reg;
        end else if ((state_reg == ST_WALK) && proc_valid_reg && !walk_ge) begin
            rank_we    = 1'b1;
        end

        out_load          = (state_reg == ST_EMIT_CHK) && kept && out_can_load;
        out_word.index    = tnis_pkg::INDEX_W'(emit_idx_reg[AW-1:0]);
        out_word.is_final = ((emit_num_reg + KW'(1)) == k_reg);
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        val_next        = val_reg;
        last_next       = last_reg;
        rd_idx_next     = rd_idx_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        rank_acc_next   = rank_acc_reg;
        k_next          = k_reg;
        emit_idx_next   = emit_idx_reg;
        emit_num_next   = emit_num_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next  = s_value;
                    last_next = s_is_last;
                    if (cnt_reg < CNT_W'(MAX_ITEMS)) begin
                        state_next    = ST_WALK;
                        rd_idx_next   = '0;
                        rank_acc_next = '0;
                    end else if (s_is_last) begin
                        // list full: word dropped, flag still closes the list
                        state_next    = ST_EMIT_RD;
                        k_next        = k_eff;
                        emit_idx_next = '0;
                        emit_num_next = '0;
                    end
                end
            end
            ST_WALK: begin
                if (rd_issue) begin
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    proc_valid_next = 1'b1;
                    proc_idx_next   = rd_idx_reg[AW-1:0];
                end
                if (proc_valid_reg && walk_ge) begin
                    rank_acc_next = rank_acc_reg + RW'(1);
                end
                if (walk_done) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_reg) begin
                        state_next    = ST_EMIT_RD;
                        k_next        = k_eff;
                        emit_idx_next = '0;
                        emit_num_next = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_CHK;
            end
            ST_EMIT_CHK: begin
                // stall only when a kept index meets a full output register
                if (!kept || out_can_load) begin
                    if (kept) begin
                        emit_num_next = emit_num_reg + KW'(1);
                    end
                    if (emit_end) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        state_next    = ST_EMIT_RD;
                        emit_idx_next = emit_idx_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
            keep_cfg_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            proc_valid_reg <= proc_valid_next;
            if (cfg_wr_en) begin
                keep_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg      <= val_next;
        last_reg     <= last_next;
        rd_idx_reg   <= rd_idx_next;
        proc_idx_reg <= proc_idx_next;
        rank_acc_reg <= rank_acc_next;
        k_reg        <= k_next;
        emit_idx_reg <= emit_idx_next;
        emit_num_reg <= emit_num_next;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_ITEMS))
        else $error("loaded count beyond capacity");

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_CHK)
        |-> (k_reg != '0) && (k_reg <= KW'(cnt_reg)))
        else $error("effective keep count out of range during scan");

    a_no_over_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_CHK) |-> (emit_num_reg <= k_reg))
        else $error("more indices emitted than the keep count");

    a_walk_wr_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        rank_we |-> (state_reg == ST_WALK) && (CNT_W'(rank_waddr) <= cnt_reg))
        else $error("rank write outside the loaded entries");

    a_final_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_word.is_final) |=> (emit_num_reg == k_reg))
        else $error("final flag not on the last kept index");
`endif

endmodule

`default_nettype wire

// ===== hdl/tnis_ram.sv =====
// ---------------------------------------------------------------------------
// tnis_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tnis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tnis_out_stage.sv =====
// ---------------------------------------------------------------------------
// tnis_out_stage
// Output register for result words; decouples the scan from m_ready.
// ---------------------------------------------------------------------------
`default_nettype none

module tnis_out_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire tnis_pkg::out_word_t        load_word,
    output logic                            can_load,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [tnis_pkg::INDEX_W-1:0]    m_index,
    output logic                            m_is_final
);

    logic                valid_reg;
    tnis_pkg::out_word_t word_reg;

    // free when empty or draining this cycle
    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid    = valid_reg;
    assign m_index    = word_reg.index;
    assign m_is_final = word_reg.is_final;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> can_load)
        else $error("out_stage: load while holding an unaccepted word");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top_n_index_selector_core.sv =====
// ---------------------------------------------------------------------------
// tb_top_n_index_selector_core
// Self-checking bench: loads lists of values, predicts the kept indices.
// ---------------------------------------------------------------------------
// A directed table covers lists of one, value extremes, ties, keep count
// clipping and the half-list default. Random lists follow, most of them
// short, with one list that runs past capacity. Both channels idle at
// random, and the keep count changes between lists while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top_n_index_selector_core;

    localparam int VALUE_W     = tnis_pkg::VALUE_W;
    localparam int KEEP_W      = tnis_pkg::KEEP_W;
    localparam int RANK_W      = tnis_pkg::RANK_W;
    localparam int INDEX_W     = tnis_pkg::INDEX_W;
    localparam int MAX_ITEMS   = 64;
    localparam int RAND_ITEMS  = 240;
    // full scan of a list plus slack
    localparam int SETTLE_CYC  = 2 * MAX_ITEMS + 16;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
    localparam logic [KEEP_W-1:0]  KEEP_AUTO = '0;  // half the list, at least one

    typedef enum int {VAL_WIDE, VAL_TIES, VAL_EDGE} val_mode_t;

    // One row of the directed table; typed rows carry their single result
    typedef struct packed {
        logic               set_keep;
        logic [KEEP_W-1:0]  keep;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        logic [INDEX_W-1:0] want_index;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [KEEP_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_value;
    logic                 s_is_last;
    logic                 m_valid;
    logic                 m_ready;
    logic [INDEX_W-1:0]   m_index;
    logic                 m_is_final;

    // shadow of the list held by the block
    logic [VALUE_W-1:0]   shadow_val  [MAX_ITEMS];
    logic [RANK_W-1:0]    shadow_rank [MAX_ITEMS];
    int                   shadow_cnt;
    logic [KEEP_W-1:0]    shadow_keep;

    tnis_pkg::out_word_t  picked[$];         // kept indices of the list just closed
    tnis_pkg::out_word_t  pending_picks[$];  // result words still owed by the block
    tnis_pkg::out_word_t  head_pick;
    dir_row_t             dir_rows[$];
    int                   err_cnt;
    bit                   in_calm;
    bit                   out_calm;

    top_n_index_selector_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_index     (m_index),
        .m_is_final  (m_is_final)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d, expected %0d", what, got, exp_val);
        err_cnt++;
    endtask

    // Stores one element, re-ranks the list and, on the last word, picks
    // the indices whose rank is below the effective keep count.
    function automatic void rank_and_pick(input logic [VALUE_W-1:0] v, input logic last);
        int                  k;
        int                  last_hit;
        logic [RANK_W-1:0]   r;
        tnis_pkg::out_word_t w;
        picked.delete();
        if (shadow_cnt < MAX_ITEMS) begin
            r = '0;
            for (int i = 0; i < shadow_cnt; i++) begin
                // larger or equal-and-earlier elements push the new one down
                if (shadow_val[i] >= v) begin
                    r = r + 1'b1;
                end else begin
                    shadow_rank[i] = shadow_rank[i] + 1'b1;
                end
            end
            shadow_val[shadow_cnt]  = v;
            shadow_rank[shadow_cnt] = r;
            shadow_cnt++;
        end
        if (!last) return;
        if (shadow_keep != 0) begin
            k = shadow_keep;
        end else begin
            k = (shadow_cnt / 2 < 1) ? 1 : shadow_cnt / 2;
        end
        if (k > shadow_cnt) k = shadow_cnt;
        last_hit = -1;
        for (int i = 0; i < shadow_cnt; i++) begin
            if (shadow_rank[i] < k) last_hit = i;
        end
        for (int i = 0; i < shadow_cnt; i++) begin
            if (shadow_rank[i] < k) begin
                w.index    = INDEX_W'(i);
                w.is_final = (i == last_hit);
                picked.insert(picked.size(), w);
            end
        end
        shadow_cnt = 0;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value(input val_mode_t mode);
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case (mode)
            VAL_TIES: return $urandom_range(0, 3);
            VAL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return VALUE_MAX;
                    2:       return VALUE_MAX - 1'b1;
                    3:       return 1;
                    default: return wide[VALUE_W-1:0];
                endcase
            end
            default: return wide[VALUE_W-1:0];
        endcase
    endfunction

    function automatic void add_dir(input logic set_keep, input logic [KEEP_W-1:0] keep,
                                    input logic [VALUE_W-1:0] value, input logic last,
                                    input logic typed, input logic [INDEX_W-1:0] want);
        dir_row_t new_row;
        new_row = {set_keep, keep, value, last, typed, want};
        dir_rows.insert(dir_rows.size(), new_row);
    endfunction

    // Drives one word and holds it until accepted. Valid stays high across
    // back-to-back words, so it is only lowered when a gap follows.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic last,
                             input logic typed, input logic [INDEX_W-1:0] want);
        int                  gap;
        tnis_pkg::out_word_t w;
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_value   <= v;
        s_is_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rank_and_pick(v, last);
        if (typed) begin
            w.index    = want;
            w.is_final = 1'b1;
            pending_picks.insert(pending_picks.size(), w);
        end else begin
            foreach (picked[i]) pending_picks.insert(pending_picks.size(), picked[i]);
        end
    endtask

    // keep count only changes once the block has drained
    task automatic write_keep(input logic [KEEP_W-1:0] k);
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_keep = k;
    endtask

    // result side: random back-pressure with calm stretches
    initial begin : rx_pacing
        int n;
        m_ready = 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
            n = out_calm ? 0 : pick_gap();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                report_mismatch("word with nothing pending, index", m_index, -1);
            end else begin
                head_pick = pending_picks.pop_front();
                if (m_index !== head_pick.index) begin
                    report_mismatch("index", m_index, head_pick.index);
                end
                if (m_is_final !== head_pick.is_final) begin
                    report_mismatch("is_final", m_is_final, head_pick.is_final);
                end
            end
        end
    end

    // ends the run when no word moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        dir_row_t  row;
        val_mode_t mode;
        int        rand_items;
        int        len;
        bit        over_done;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_value     = '0;
        s_is_last   = 1'b0;
        shadow_cnt  = 0;
        shadow_keep = '0;
        err_cnt     = 0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;

        // lists of one under the reset keep count
        add_dir(0, 0, '0, 1, 1, 0);
        add_dir(0, 0, VALUE_MAX, 1, 1, 0);
        // keep one: the largest wins
        add_dir(1, 1, 5, 0, 0, 0);
        add_dir(0, 0, VALUE_MAX, 0, 0, 0);
        add_dir(0, 0, 3, 0, 0, 0);
        add_dir(0, 0, 7, 1, 1, 1);
        // keep count above the list length: every index comes out
        add_dir(1, KEEP_W'(MAX_ITEMS), 9, 0, 0, 0);
        add_dir(0, 0, 9, 0, 0, 0);
        add_dir(0, 0, 9, 0, 0, 0);
        add_dir(0, 0, 9, 1, 0, 0);
        // ties: the earlier of equal values ranks higher
        add_dir(1, 2, 7, 0, 0, 0);
        add_dir(0, 0, 7, 0, 0, 0);
        add_dir(0, 0, 0, 0, 0, 0);
        add_dir(0, 0, 7, 0, 0, 0);
        add_dir(0, 0, 7, 1, 0, 0);
        // zero keep count: half of six
        add_dir(1, KEEP_AUTO, 48'hAAAA_AAAA_AAAA, 0, 0, 0);
        add_dir(0, 0, 48'h5555_5555_5555, 0, 0, 0);
        add_dir(0, 0, '0, 0, 0, 0);
        add_dir(0, 0, VALUE_MAX, 0, 0, 0);
        add_dir(0, 0, 1, 0, 0, 0);
        add_dir(0, 0, 48'h8000_0000_0000, 1, 0, 0);
        // keep three on a list of two
        add_dir(1, 3, 2, 0, 0, 0);
        add_dir(0, 0, 1, 1, 0, 0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.set_keep) write_keep(row.keep);
            send_word(row.value, row.last, row.typed, row.want_index);
        end

        // random lists; one runs a few words past capacity, last flag included
        rand_items = 0;
        over_done  = 1'b0;
        while (rand_items < RAND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       write_keep(KEEP_AUTO);
                    1:       write_keep(KEEP_W'(1));
                    2:       write_keep(KEEP_W'(MAX_ITEMS));
                    default: write_keep(KEEP_W'($urandom_range(0, MAX_ITEMS)));
                endcase
            end
            if (!over_done && rand_items >= 100) begin
                len       = MAX_ITEMS + $urandom_range(1, 3);
                over_done = 1'b1;
            end else if ($urandom_range(0, 11) == 0) begin
                len = $urandom_range(16, 40);
            end else begin
                len = $urandom_range(1, 10);
            end
            mode = val_mode_t'($urandom_range(0, 2));
            for (int j = 0; j < len; j++) begin
                send_word(rand_value(mode), j == len - 1, 1'b0, '0);
            end
            rand_items += len;
        end

        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
